// ----- hdl/bba_pkg.sv -----
package bba_pkg;

  // Field widths
  localparam int unsigned ActionW  = 2;
  localparam int unsigned BlockW   = 12;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgW     = 10;

  // A 12-bit block number reaches at most this many bitmap bytes
  localparam int unsigned AddrBytes     = 512;
  localparam int unsigned MapBytesDef   = 512;
  localparam logic [CfgW-1:0] CfgReset  = 10'd512;

  // Bytes of the full-flag summary examined per scan step
  localparam int unsigned GroupBytes = 32;

  localparam logic [7:0] FullByte = 8'hFF;

  // Request actions
  localparam logic [ActionW-1:0] ACT_TEST = 2'd0;
  localparam logic [ActionW-1:0] ACT_FIND = 2'd1;
  localparam logic [ActionW-1:0] ACT_USE  = 2'd2;
  localparam logic [ActionW-1:0] ACT_FREE = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] STS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STS_RANGE = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;     // write one zero byte of the clearing pass
    logic accept;     // request transaction taken
    logic scan_step;  // examine one group of full flags
    logic exec;       // read data valid: form result, write back
    logic emit;       // move result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_is_find;
    logic in_range_err;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- hdl/bba_if.sv -----
// Request channel
interface bba_req_if;
  logic                              valid;
  logic                              ready;
  logic [bba_pkg::ActionW-1:0]       action;
  logic [bba_pkg::BlockW-1:0]        block_index;

  modport source (output valid, action, block_index, input ready);
  modport sink   (input valid, action, block_index, output ready);
endinterface

// Response channel
interface bba_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              is_free;
  logic [bba_pkg::BlockW-1:0]        found_block;
  logic [bba_pkg::StatusW-1:0]       status;

  modport source (output valid, is_free, found_block, status, input ready);
  modport sink   (input valid, is_free, found_block, status, output ready);
endinterface

// Configuration write channel
interface bba_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bba_pkg::CfgW-1:0]          map_bytes_used;

  modport source (output valid, map_bytes_used, input ready);
  modport sink   (input valid, map_bytes_used, output ready);
endinterface

// ----- hdl/bba_ctrl.sv -----
module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bba_pkg::ctrl_sts_t sts_i,
  output bba_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_is_find) begin
            state_d = ST_SCAN;
          end else if (sts_i.in_range_err) begin
            state_d = ST_EXEC;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_READ;
        end else if (sts_i.scan_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A result only moves out when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted into a busy output register");

  // No request is taken before the clearing pass has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_o.accept && !in_ready_o)
    else $error("request taken during clearing pass");

  // A scan always ends within its group budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_step && sts_i.scan_last) |=> (state_q != ST_SCAN))
    else $error("scan ran past last group");

endmodule

// ----- hdl/bba_datapath.sv -----
module bba_datapath #(
  parameter int unsigned MAP_BYTES = bba_pkg::MapBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bba_pkg::ActionW-1:0]  action_i,
  input  logic [bba_pkg::BlockW-1:0]   block_index_i,
  bba_rsp_if.source                    rsp,
  bba_cfg_if.sink                      cfg,
  input  bba_pkg::ctrl_cmd_t           cmd_i,
  output bba_pkg::ctrl_sts_t           sts_o
);

  // Bytes that can actually be addressed
  localparam int unsigned Depth   = (MAP_BYTES < bba_pkg::AddrBytes) ? MAP_BYTES
                                                                    : bba_pkg::AddrBytes;
  localparam int unsigned AW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW      = $clog2(Depth + 1);
  localparam int unsigned GB      = bba_pkg::GroupBytes;
  localparam int unsigned NGroups = (Depth + GB - 1) / GB;
  localparam int unsigned GW      = (NGroups > 1) ? $clog2(NGroups) : 1;
  localparam int unsigned PW      = $clog2(GB);
  localparam int unsigned IW      = GW + PW + 1;
  localparam int unsigned LimW    = bba_pkg::CfgW + 3;

  // Bitmap store and per-byte full flags
  logic [7:0]                    mem [Depth];
  logic [7:0]                    rd_data_q;
  logic [Depth-1:0]              full_q;
  logic [NGroups*GB-1:0]         full_pad;

  logic [bba_pkg::CfgW-1:0]      cfg_q;
  logic [bba_pkg::CfgW-1:0]      nbytes;
  logic [CW-1:0]                 clr_cnt_q;

  logic [bba_pkg::ActionW-1:0]   act_q;
  logic                          range_q;
  logic                          hit_q;
  logic [AW-1:0]                 byte_addr_q;
  logic [2:0]                    bit_sel_q;
  logic [GW-1:0]                 grp_q;

  logic                          res_free_q;
  logic [bba_pkg::BlockW-1:0]    res_found_q;
  logic [bba_pkg::StatusW-1:0]   res_status_q;

  logic                          out_valid_q;
  logic                          out_free_q;
  logic [bba_pkg::BlockW-1:0]    out_found_q;
  logic [bba_pkg::StatusW-1:0]   out_status_q;

  logic                          in_range_err;
  logic [GB-1:0]                 avail;
  logic                          scan_hit;
  logic [PW-1:0]                 scan_pos;
  logic [AW-1:0]                 hit_addr;
  logic [2:0]                    zero_bit;
  logic [7:0]                    bit_mask;
  logic [7:0]                    wr_byte;
  logic                          mark_we;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [7:0]                    mem_wdata;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bba_pkg::CfgReset;
    end else if (cfg.valid) begin
      cfg_q <= cfg.map_bytes_used;
    end
  end

  assign nbytes = (cfg_q > bba_pkg::CfgW'(Depth)) ? bba_pkg::CfgW'(Depth) : cfg_q;

  // Range check on the incoming request
  assign in_range_err = LimW'(block_index_i) >= (LimW'(nbytes) << 3);

  // Scan one group of full flags for the lowest byte in use that has room
  assign full_pad = {{(NGroups*GB-Depth){1'b1}}, full_q};

  always_comb begin
    logic [IW-1:0] idx;
    avail    = '0;
    scan_pos = '0;
    for (int i = 0; i < GB; i++) begin
      idx      = (IW'(grp_q) << PW) + IW'(i);
      avail[i] = !full_pad[idx[IW-2:0]] && (idx < IW'(nbytes));
    end
    for (int i = GB - 1; i >= 0; i--) begin
      if (avail[i]) begin
        scan_pos = PW'(i);
      end
    end
  end

  assign scan_hit = |avail;
  assign hit_addr = AW'((IW'(grp_q) << PW) + IW'(scan_pos));

  // Lowest clear bit of the read byte
  always_comb begin
    zero_bit = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!rd_data_q[i]) begin
        zero_bit = 3'(i);
      end
    end
  end

  // Write-back value for mark actions
  assign bit_mask = 8'd1 << bit_sel_q;
  assign wr_byte  = (act_q == bba_pkg::ACT_USE) ? (rd_data_q | bit_mask)
                                                : (rd_data_q & ~bit_mask);
  assign mark_we  = cmd_i.exec && !range_q &&
                    (act_q == bba_pkg::ACT_USE || act_q == bba_pkg::ACT_FREE);
  assign mem_we    = cmd_i.clr_en || mark_we;
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q[AW-1:0] : byte_addr_q;
  assign mem_wdata = cmd_i.clr_en ? 8'd0 : wr_byte;

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[byte_addr_q];
  end

  // Full flags follow every mark write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (mark_we) begin
      full_q[byte_addr_q] <= (wr_byte == bba_pkg::FullByte);
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
    end
  end

  // Request context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= bba_pkg::ACT_TEST;
      range_q     <= 1'b0;
      hit_q       <= 1'b0;
      grp_q       <= '0;
      byte_addr_q <= '0;
      bit_sel_q   <= '0;
    end else if (cmd_i.accept) begin
      act_q       <= action_i;
      range_q     <= (action_i != bba_pkg::ACT_FIND) && in_range_err;
      hit_q       <= 1'b0;
      grp_q       <= '0;
      byte_addr_q <= AW'(block_index_i >> 3);
      bit_sel_q   <= block_index_i[2:0];
    end else if (cmd_i.scan_step) begin
      grp_q <= grp_q + GW'(1);
      if (scan_hit) begin
        hit_q       <= 1'b1;
        byte_addr_q <= hit_addr;
      end
    end
  end

  // Result formed from the read byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_free_q   <= (act_q == bba_pkg::ACT_TEST) && !range_q && !rd_data_q[bit_sel_q];
      res_found_q  <= ((act_q == bba_pkg::ACT_FIND) && hit_q)
                      ? bba_pkg::BlockW'({byte_addr_q, zero_bit}) : '0;
      if (act_q == bba_pkg::ACT_FIND) begin
        res_status_q <= hit_q ? bba_pkg::STS_OK : bba_pkg::STS_FULL;
      end else begin
        res_status_q <= range_q ? bba_pkg::STS_RANGE : bba_pkg::STS_OK;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_free_q   <= res_free_q;
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.is_free     = out_free_q;
  assign rsp.found_block = out_found_q;
  assign rsp.status      = out_status_q;

  // Status to the controller
  assign sts_o.clr_last     = (clr_cnt_q == CW'(Depth - 1));
  assign sts_o.in_is_find   = (action_i == bba_pkg::ACT_FIND);
  assign sts_o.in_range_err = in_range_err;
  assign sts_o.scan_hit     = scan_hit;
  assign sts_o.scan_last    = (grp_q == GW'(NGroups - 1));
  assign sts_o.out_free     = !out_valid_q || rsp.ready;

  // A successful find must land on a byte that still has a clear bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && act_q == bba_pkg::ACT_FIND && hit_q) |-> (rd_data_q != bba_pkg::FullByte))
    else $error("find picked a full byte");

  // Mark writes never happen for out-of-range requests or during clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_we |-> !cmd_i.clr_en && !range_q)
    else $error("illegal bitmap write");

  // A full or range status never carries a block number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != bba_pkg::STS_OK) |-> (out_found_q == '0) && !out_free_q)
    else $error("error result with payload");

endmodule

// ----- hdl/block_bitmap_allocator.sv -----
// Free-space bitmap allocator: one bit per data block, 1 = in use.
// Request channel (req): action and block_index; one transaction is one
// request. Actions: test free, find lowest free block, mark used, mark
// free. Response channel (rsp): is_free, found_block and status for each
// request, in request order, exactly one response per request.
// Configuration channel (cfg): map_bytes_used; the user must write it only
// while the block is idle, which the block itself does not enforce. It
// limits the blocks managed to 8 * min(map_bytes_used, bytes stored).
// cfg is always ready. A test or mark reads the bitmap byte, then forms
// the result and moves it to the output register; an out-of-range one
// skips the read. A find scans 32 byte-full flags per cycle, stops at the
// first group with a hit, and on a full map runs all 16 groups (default size).
// One request is in flight at a time; the next is taken once the result
// has entered the output register.
// Reset: the bitmap memory is cleared by a pass of one byte per cycle,
// and req.ready stays low until the pass is done.
// cfg returns to 512. A stalled response is held in the output register
// while the next request is taken; that request then waits for the slot.
module block_bitmap_allocator #(
  parameter int unsigned MAP_BYTES = bba_pkg::MapBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bba_req_if.sink     req,
  bba_rsp_if.source   rsp,
  bba_cfg_if.sink     cfg
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::ctrl_sts_t sts;
  logic               in_ready;

  assign req.ready = in_ready;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .MAP_BYTES (MAP_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (req.action),
    .block_index_i (req.block_index),
    .rsp           (rsp),
    .cfg           (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
